// ----- rtl/wcsa_pkg.sv -----
// ----------------------------------------------------------------------------
// wcsa_pkg
// Shared types and constants for the within-class scatter accumulator.
// ----------------------------------------------------------------------------
package wcsa_pkg;

    // Fixed field widths
    localparam int VALUE_BITS = 16;
    localparam int ACC_BITS   = 64;
    localparam int IDX_BITS   = 3;

    // Default matrix dimension
    localparam int DIM_DEF = 8;

    // Request mode codes
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Request transaction
    typedef struct packed {
        logic [1:0]                   mode;
        logic signed [VALUE_BITS-1:0] sample_value;
        logic signed [VALUE_BITS-1:0] mean_value;
        logic                         last_element;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic [IDX_BITS-1:0]        row_index;
        logic [IDX_BITS-1:0]        column_index;
        logic signed [ACC_BITS-1:0] entry_value;
        logic                       last_entry;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic cvec_wr;
        logic cvec_rd;
        logic load_dk;
        logic acc_rd;
        logic acc_pipe;
        logic out_load;
        logic clear_all;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_busy;
    } sts_t;

endpackage

// ----- rtl/wcsa_datapath.sv -----
// ----------------------------------------------------------------------------
// wcsa_datapath
// Centred vector store, shared multiply-accumulate pipeline with saturation,
// accumulator memory with per-entry valid bits, and the entry output register.
// ----------------------------------------------------------------------------
module wcsa_datapath #(
    parameter int DIM = 8,
    parameter int IW  = 3,
    parameter int AW  = 6
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wcsa_pkg::cmd_t                        cmd,
    output wcsa_pkg::sts_t                        sts,
    input  logic signed [wcsa_pkg::VALUE_BITS-1:0] sample_value,
    input  logic signed [wcsa_pkg::VALUE_BITS-1:0] mean_value,
    input  logic [IW-1:0]                         cvec_wr_addr,
    input  logic [IW-1:0]                         cvec_rd_addr,
    input  logic [AW-1:0]                         acc_addr,
    output logic signed [wcsa_pkg::ACC_BITS-1:0]  entry_value
);
    import wcsa_pkg::*;

    localparam int DW    = VALUE_BITS + 1;
    localparam int PW    = 2 * DW;
    localparam int DEPTH = DIM * DIM;

    // Centred vector store
    logic signed [DW-1:0] cvec_mem [DIM];
    logic signed [DW-1:0] cv_rd_reg;
    logic signed [DW-1:0] dk_reg;
    logic signed [DW-1:0] diff;

    // Accumulator store
    logic signed [ACC_BITS-1:0] acc_mem [DEPTH];
    logic [DEPTH-1:0]           acc_vld_reg;
    logic signed [ACC_BITS-1:0] acc_rd_reg;
    logic                       vld_rd_reg;

    // Pipeline
    logic                       s1_vld_reg;
    logic                       s2_vld_reg;
    logic [AW-1:0]              s1_addr_reg;
    logic [AW-1:0]              s2_addr_reg;
    logic signed [PW-1:0]       prod_reg;
    logic signed [PW-1:0]       prod_next;
    logic signed [ACC_BITS-1:0] s2_acc_reg;
    logic signed [ACC_BITS-1:0] prod_ext;
    logic signed [ACC_BITS:0]   sum_wide;
    logic signed [ACC_BITS-1:0] sum_sat;
    logic signed [ACC_BITS-1:0] acc_cur;
    logic signed [ACC_BITS-1:0] entry_reg;

    // Form the centred difference
    assign diff = DW'(sample_value) - DW'(mean_value);

    // Write and read the centred vector
    always_ff @(posedge clk)
    begin
        if (cmd.cvec_wr)
        begin
            cvec_mem[cvec_wr_addr] <= diff;
        end
        if (cmd.cvec_rd)
        begin
            cv_rd_reg <= cvec_mem[cvec_rd_addr];
        end
        if (cmd.load_dk)
        begin
            dk_reg <= cv_rd_reg;
        end
    end

    // Read an accumulator entry, write back the saturated sum
    always_ff @(posedge clk)
    begin
        if (s2_vld_reg)
        begin
            acc_mem[s2_addr_reg] <= sum_sat;
        end
        if (cmd.acc_rd)
        begin
            acc_rd_reg <= acc_mem[acc_addr];
            vld_rd_reg <= acc_vld_reg[acc_addr];
        end
    end

    // Track which entries hold a written value; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= '0;
        end
        else if (cmd.clear_all)
        begin
            acc_vld_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_vld_reg[s2_addr_reg] <= 1'b1;
        end
    end

    assign acc_cur = vld_rd_reg ? acc_rd_reg : '0;

    // Advance the pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.acc_pipe;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // Multiply stage
    assign prod_next = PW'(dk_reg) * PW'(cv_rd_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.acc_pipe)
        begin
            s1_addr_reg <= acc_addr;
        end
        if (s1_vld_reg)
        begin
            prod_reg    <= prod_next;
            s2_addr_reg <= s1_addr_reg;
            s2_acc_reg  <= acc_cur;
        end
    end

    // Saturating add
    assign prod_ext = ACC_BITS'(prod_reg);
    assign sum_wide = (ACC_BITS+1)'(s2_acc_reg) + (ACC_BITS+1)'(prod_ext);

    always_comb
    begin
        if (sum_wide[ACC_BITS] != sum_wide[ACC_BITS-1])
        begin
            sum_sat = sum_wide[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                         : {1'b0, {(ACC_BITS-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[ACC_BITS-1:0];
        end
    end

    // Hold the read-out entry
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            entry_reg <= acc_cur;
        end
    end

    assign entry_value   = entry_reg;
    assign sts.pipe_busy = s1_vld_reg | s2_vld_reg;

endmodule

// ----- rtl/wcsa_controller.sv -----
// ----------------------------------------------------------------------------
// wcsa_controller
// Request decode, element position tracking, outer-product sequencing and
// read-out sequencing with the response handshake.
// ----------------------------------------------------------------------------
module wcsa_controller #(
    parameter int DIM = 8,
    parameter int IW  = 3,
    parameter int AW  = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    mode,
    input  logic                          last_element,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output wcsa_pkg::cmd_t                cmd,
    input  wcsa_pkg::sts_t                sts,
    output logic [IW-1:0]                 cvec_wr_addr,
    output logic [IW-1:0]                 cvec_rd_addr,
    output logic [AW-1:0]                 acc_addr,
    output logic [wcsa_pkg::IDX_BITS-1:0] row_index,
    output logic [wcsa_pkg::IDX_BITS-1:0] column_index,
    output logic                          last_entry
);
    import wcsa_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROW   = 3'd1;
    localparam logic [2:0] ST_COL   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_RDW   = 3'd4;
    localparam logic [2:0] ST_OWAIT = 3'd5;

    localparam logic [IW-1:0] LAST_IDX = IW'(DIM - 1);

    logic [2:0]          state_reg,  state_next;
    logic [IW-1:0]       pos_reg,    pos_next;
    logic [IW-1:0]       kmax_reg,   kmax_next;
    logic [IW-1:0]       k_reg,      k_next;
    logic [IW-1:0]       l_reg,      l_next;
    logic [AW-1:0]       addr_reg,   addr_next;
    logic [IDX_BITS-1:0] row_reg;
    logic [IDX_BITS-1:0] col_reg;
    logic                last_reg;
    logic                accept;
    logic                rd_last;

    assign accept  = req_valid && (state_reg == ST_IDLE);
    assign rd_last = (k_reg == LAST_IDX) && (l_reg == LAST_IDX);

    // Sequence the block
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        kmax_next    = kmax_reg;
        k_next       = k_reg;
        l_next       = l_reg;
        addr_next    = addr_reg;
        cmd          = '0;
        cvec_wr_addr = pos_reg;
        cvec_rd_addr = k_reg;
        acc_addr     = addr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_SAMPLE:
                        begin
                            cmd.cvec_wr = 1'b1;
                            if (last_element)
                            begin
                                kmax_next  = pos_reg;
                                pos_next   = '0;
                                k_next     = '0;
                                l_next     = '0;
                                state_next = ST_ROW;
                            end
                            else if (pos_reg != LAST_IDX)
                            begin
                                pos_next = pos_reg + 1'b1;
                            end
                        end
                        MODE_READ:
                        begin
                            cmd.acc_rd = 1'b1;
                            acc_addr   = '0;
                            addr_next  = AW'(1);
                            k_next     = '0;
                            l_next     = '0;
                            state_next = ST_RDW;
                        end
                        MODE_CLEAR:
                        begin
                            cmd.clear_all = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Fetch the row element d_k
            ST_ROW:
            begin
                cmd.cvec_rd  = 1'b1;
                cvec_rd_addr = k_reg;
                state_next   = ST_COL;
            end

            // Issue one multiply-accumulate per column
            ST_COL:
            begin
                cmd.load_dk  = (l_reg == '0);
                cmd.cvec_rd  = 1'b1;
                cmd.acc_rd   = 1'b1;
                cmd.acc_pipe = 1'b1;
                cvec_rd_addr = l_reg;
                acc_addr     = AW'(k_reg) * AW'(DIM) + AW'(l_reg);
                if (l_reg == kmax_reg)
                begin
                    l_next = '0;
                    if (k_reg == kmax_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_ROW;
                    end
                end
                else
                begin
                    l_next = l_reg + 1'b1;
                end
            end

            // Wait for the last write-back
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end

            // Capture the read entry
            ST_RDW:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_OWAIT;
            end

            // Hold the response until taken, then fetch the next entry
            ST_OWAIT:
            begin
                if (!rsp_stall)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.acc_rd = 1'b1;
                        acc_addr   = addr_reg;
                        addr_next  = addr_reg + 1'b1;
                        if (l_reg == LAST_IDX)
                        begin
                            l_next = '0;
                            k_next = k_reg + 1'b1;
                        end
                        else
                        begin
                            l_next = l_reg + 1'b1;
                        end
                        state_next = ST_RDW;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            kmax_reg  <= '0;
            k_reg     <= '0;
            l_reg     <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            kmax_reg  <= kmax_next;
            k_reg     <= k_next;
            l_reg     <= l_next;
            addr_reg  <= addr_next;
        end
    end

    // Response tags
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            row_reg  <= IDX_BITS'(k_reg);
            col_reg  <= IDX_BITS'(l_reg);
            last_reg <= rd_last;
        end
    end

    assign req_stall    = (state_reg != ST_IDLE);
    assign rsp_valid    = (state_reg == ST_OWAIT);
    assign row_index    = row_reg;
    assign column_index = col_reg;
    assign last_entry   = last_reg;

endmodule

// ----- rtl/within_class_scatter_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// within_class_scatter_accumulator_top
// Accumulates the within-class scatter matrix from centred samples and reads
// it out row-major on request.
//
//   channel | dir | payload | handshake
//   req     | in  | req_t   | req_valid / req_stall
//   rsp     | out | rsp_t   | rsp_valid / rsp_stall
//
// A sample element or a clear leaves the block idle. The last element of an
// n-element sample starts the outer-product update: n rows, each a row fetch
// then n column steps through the single multiply-accumulate pipe, then a
// drain. A read-out captures each entry and holds it while rsp_stall is high.
// Reset clears the accumulator at once through per-entry valid bits.
// req_stall is high whenever an update or a read-out is in progress.
// ----------------------------------------------------------------------------
module within_class_scatter_accumulator_top #(
    parameter int DIM = wcsa_pkg::DIM_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  wcsa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output wcsa_pkg::rsp_t rsp
);
    import wcsa_pkg::*;

    localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int AW = (DIM > 1) ? $clog2(DIM * DIM) : 1;

    cmd_t                       cmd;
    sts_t                       sts;
    logic [IW-1:0]              cvec_wr_addr;
    logic [IW-1:0]              cvec_rd_addr;
    logic [AW-1:0]              acc_addr;
    logic [IDX_BITS-1:0]        row_index;
    logic [IDX_BITS-1:0]        column_index;
    logic                       last_entry;
    logic signed [ACC_BITS-1:0] entry_value;

    wcsa_controller #(
        .DIM (DIM),
        .IW  (IW),
        .AW  (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .mode         (req.mode),
        .last_element (req.last_element),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .cmd          (cmd),
        .sts          (sts),
        .cvec_wr_addr (cvec_wr_addr),
        .cvec_rd_addr (cvec_rd_addr),
        .acc_addr     (acc_addr),
        .row_index    (row_index),
        .column_index (column_index),
        .last_entry   (last_entry)
    );

    wcsa_datapath #(
        .DIM (DIM),
        .IW  (IW),
        .AW  (AW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .sample_value (req.sample_value),
        .mean_value   (req.mean_value),
        .cvec_wr_addr (cvec_wr_addr),
        .cvec_rd_addr (cvec_rd_addr),
        .acc_addr     (acc_addr),
        .entry_value  (entry_value)
    );

    // Assemble the response transaction
    assign rsp.row_index    = row_index;
    assign rsp.column_index = column_index;
    assign rsp.entry_value  = entry_value;
    assign rsp.last_entry   = last_entry;

endmodule
